// ===== src/lkvc_pkg.sv =====
// Package for the LRU key-value cache: sizes, command codes and constants.
// No dependencies; imported by lru_key_value_cache_core.
package lkvc_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int CAP_W     = 5;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] READ_MISS  = {VAL_W{1'b1}};

    typedef enum logic [0:0]
    {
        CMD_LOOKUP = 1'b0,
        CMD_STORE  = 1'b1
    } cmd_t;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [IDX_W-1:0] rank_t;
    typedef logic [CNT_W-1:0] cnt_t;

endpackage

// ===== src/lru_key_value_cache_core.sv =====
// Top level of the LRU key-value cache: input register, parallel lookup and
// recency update, result register. Depends on lkvc_pkg.
//
// A fully associative cache of lkvc_pkg::ENTRIES key/value pairs with
// least-recently-used replacement. Each transaction is a lookup or a store;
// one result transaction is returned for each. The core accepts one
// transaction per clock unless m_tready back-pressure stalls the result
// register; each passes the input register, then the result register. The
// key compare and rank update run in parallel over the entry registers.
// capacity_in_use (cfg_wr_data) must be written only while the core is idle;
// the core does not enforce this. 0 behaves as 1 and values above ENTRIES behave as ENTRIES.
module lru_key_value_cache_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data,   // capacity_in_use
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,       // [31:0] lookup_key, [63:32] store_value
    input  logic [0:0]                  s_tuser,       // [0] command
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,       // [31:0] read_value
    output logic [1:0]                  m_tuser        // [0] hit, [1] evicted
);
    import lkvc_pkg::*;

    logic [CAP_W-1:0] cap_reg;

    logic             in_valid_reg;
    cmd_t             in_cmd_reg;
    logic [KEY_W-1:0] in_key_reg;
    logic [VAL_W-1:0] in_val_reg;

    logic             out_valid_reg;
    logic             out_hit_reg;
    logic             out_ev_reg;
    logic [VAL_W-1:0] out_rd_reg;
    logic             out_hit_next;
    logic             out_ev_next;
    logic [VAL_W-1:0] out_rd_next;

    logic [KEY_W-1:0] key_reg   [ENTRIES];
    logic [VAL_W-1:0] value_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    rank_t            rank_reg  [ENTRIES];
    rank_t            rank_next [ENTRIES];
    cnt_t             fill_reg;
    cnt_t             fill_next;

    logic             advance;
    logic             proc;
    logic [ENTRIES-1:0] hit_vec;
    logic             present;
    idx_t             found_idx;
    idx_t             free_idx;
    idx_t             lru_idx;
    idx_t             slot;
    rank_t            touch_rank;
    rank_t            lru_rank;
    logic [CMP_W-1:0] cap_eff;
    logic             room;
    logic             do_store;
    logic             do_fill;
    logic             do_evict;
    logic             do_update;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign proc     = in_valid_reg && advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rd_reg;
    assign m_tuser  = {out_ev_reg, out_hit_reg};

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = CMP_W'(cap_reg);
        end
    end

    assign room     = CMP_W'(fill_reg) < cap_eff;
    assign lru_rank = rank_t'(fill_reg - cnt_t'(1));

    always_comb
    begin
        found_idx = '0;
        free_idx  = '0;
        lru_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == in_key_reg);
            if (hit_vec[i])
            begin
                found_idx = idx_t'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = idx_t'(i);
            end
            if (valid_reg[i] && (rank_reg[i] == lru_rank))
            begin
                lru_idx = idx_t'(i);
            end
        end
    end

    assign present   = |hit_vec;
    assign do_store  = (in_cmd_reg == CMD_STORE);
    assign do_fill   = !present && do_store && room;
    assign do_evict  = !present && do_store && !room;
    assign do_update = present || do_store;

    always_comb
    begin
        if (present)
        begin
            slot = found_idx;
        end
        else if (do_fill)
        begin
            slot = free_idx;
        end
        else
        begin
            slot = lru_idx;
        end
    end

    assign touch_rank = rank_reg[slot];

    // Fill ages every valid entry; a touch ages only the more recent ones.
    always_comb
    begin
        valid_next = valid_reg;
        fill_next  = fill_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (proc && do_update)
            begin
                if (idx_t'(i) == slot)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (do_fill || (rank_reg[i] < touch_rank)))
                begin
                    rank_next[i] = rank_reg[i] + rank_t'(1);
                end
            end
        end
        if (proc && do_fill)
        begin
            valid_next[slot] = 1'b1;
            fill_next        = fill_reg + cnt_t'(1);
        end
    end

    always_comb
    begin
        out_hit_next = present;
        out_ev_next  = do_evict;
        if (present && !do_store)
        begin
            out_rd_next = value_reg[found_idx];
        end
        else
        begin
            out_rd_next = READ_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            fill_reg      <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg <= cmd_t'(s_tuser[0]);
            in_key_reg <= s_tdata[KEY_W-1:0];
            in_val_reg <= s_tdata[KEY_W+VAL_W-1:KEY_W];
        end
        if (proc)
        begin
            out_hit_reg <= out_hit_next;
            out_ev_reg  <= out_ev_next;
            out_rd_reg  <= out_rd_next;
        end
        if (proc && do_store)
        begin
            key_reg[slot]   <= in_key_reg;
            value_reg[slot] <= in_val_reg;
        end
    end

endmodule
